### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the default block clock and reset
`define ASSERT_I(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/msis_pkg.sv
package msis_pkg;

  // sample and pattern width seen on the ports
  localparam int SAMPLE_W = 8;
  // default width of the decoder inputs
  localparam int INPUT_WIDTH_DEF = 8;
  // test pattern after reset
  localparam logic [SAMPLE_W-1:0] PATTERN_RESET = 8'h7F;
  // reads of the test inputs per round
  localparam int TEST_READS = 3;
  // depth of the debounce ring
  localparam int RING_DEPTH = 6;
  // agreeing samples needed to move a filtered bit
  localparam int VOTE_MIN = 4;
  // result word width, padded to whole bytes
  localparam int RESULT_W = 16;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_ARM_DATA  = 3'd0,
    PH_READ_DATA = 3'd1,
    PH_READ_TEST = 3'd3,
    PH_WAIT      = 3'd4
  } phase_e;

  // decoder select command
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_DATA = 2'd1,
    SEL_TEST = 2'd2
  } mux_sel_e;

  // sequencer outcome of one tick
  typedef struct packed {
    mux_sel_e mux_select;
    logic     test_done;
    logic     test_fail;
    logic     ring_push;
  } seq_out_t;

endpackage

### hw/rtl/msis_seq.sv
module msis_seq #(
  parameter int DATA_W = msis_pkg::INPUT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [DATA_W-1:0] sample_i,
  input  logic [DATA_W-1:0] pattern_i,
  output msis_pkg::seq_out_t ctrl_o,
  output logic [DATA_W-1:0] held_data_o
);

  msis_pkg::phase_e phase_q, phase_d;
  msis_pkg::phase_e after_q, after_d;
  logic             pending_q, pending_d;
  logic [DATA_W-1:0] held_q, held_d;
  logic [1:0]       count_q, count_d;
  // first two test reads; the third comes straight from the input
  logic [DATA_W-1:0] ts_q [2];
  logic             ts_we;
  logic [1:0]       idx;
  logic [DATA_W-1:0] maj;

  // read slot, reduced into range
  assign idx = (count_q == 2'd3) ? 2'd0 : count_q;

  // bitwise 2-of-3 majority of the test reads
  assign maj = (ts_q[0] & ts_q[1]) | (ts_q[0] & sample_i) | (ts_q[1] & sample_i);

  // next phase and tick outputs
  always_comb begin
    phase_d   = phase_q;
    after_d   = after_q;
    pending_d = pending_q;
    held_d    = held_q;
    count_d   = count_q;
    ts_we     = 1'b0;
    ctrl_o    = '{mux_select: msis_pkg::SEL_NONE, test_done: 1'b0,
                  test_fail: 1'b0, ring_push: 1'b0};
    unique case (phase_q)
      msis_pkg::PH_ARM_DATA: begin
        pending_d = 1'b0;
        after_d   = msis_pkg::PH_READ_DATA;
        phase_d   = msis_pkg::PH_WAIT;
      end
      msis_pkg::PH_READ_DATA: begin
        held_d    = sample_i;
        pending_d = 1'b1;
        after_d   = msis_pkg::PH_READ_TEST;
        count_d   = 2'd0;
        phase_d   = msis_pkg::PH_WAIT;
      end
      msis_pkg::PH_READ_TEST: begin
        if (idx == 2'(msis_pkg::TEST_READS - 1)) begin
          count_d          = 2'd0;
          phase_d          = msis_pkg::PH_ARM_DATA;
          ctrl_o.test_done = 1'b1;
          if (maj == pattern_i) begin
            ctrl_o.ring_push = 1'b1;
          end else begin
            ctrl_o.test_fail = 1'b1;
          end
        end else begin
          ts_we   = 1'b1;
          count_d = idx + 2'd1;
        end
      end
      msis_pkg::PH_WAIT: begin
        ctrl_o.mux_select = pending_q ? msis_pkg::SEL_TEST : msis_pkg::SEL_DATA;
        phase_d           = after_q;
      end
      default: begin
        phase_d = msis_pkg::PH_ARM_DATA;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= msis_pkg::PH_ARM_DATA;
      after_q   <= msis_pkg::PH_ARM_DATA;
      pending_q <= 1'b0;
      held_q    <= '0;
      count_q   <= 2'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      after_q   <= after_d;
      pending_q <= pending_d;
      held_q    <= held_d;
      count_q   <= count_d;
    end
  end

  // test read store
  always_ff @(posedge clk_i) begin
    if (step_i && ts_we) begin
      ts_q[idx[0]] <= sample_i;
    end
  end

  assign held_data_o = held_q;

endmodule

### hw/rtl/msis_filter.sv
module msis_filter #(
  parameter int DATA_W = msis_pkg::INPUT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic [DATA_W-1:0] filt_next_o
);

  localparam int PtrW = $clog2(msis_pkg::RING_DEPTH + 2);

  logic [DATA_W-1:0] ring_q [msis_pkg::RING_DEPTH];
  logic [DATA_W-1:0] ring_new [msis_pkg::RING_DEPTH];
  logic [PtrW-1:0]   ptr_q, ptr_d, rp;
  logic [DATA_W-1:0] filt_q, vote;
  logic [msis_pkg::RING_DEPTH-1:0] column [DATA_W];

  // write slot, reduced into range
  assign rp = (ptr_q >= PtrW'(msis_pkg::RING_DEPTH)) ?
              ptr_q - PtrW'(msis_pkg::RING_DEPTH) : ptr_q;
  assign ptr_d = (rp == PtrW'(msis_pkg::RING_DEPTH - 1)) ? '0 : rp + PtrW'(1);

  // ring as it stands after this push
  always_comb begin
    for (int k = 0; k < msis_pkg::RING_DEPTH; k++) begin
      ring_new[k] = (PtrW'(k) == rp) ? data_i : ring_q[k];
    end
  end

  // 4-of-6 vote per bit, hold on a tie
  always_comb begin
    for (int b = 0; b < DATA_W; b++) begin
      for (int k = 0; k < msis_pkg::RING_DEPTH; k++) begin
        column[b][k] = ring_new[k][b];
      end
      if ($countones(column[b]) >= msis_pkg::VOTE_MIN) begin
        vote[b] = 1'b1;
      end else if ($countones(~column[b]) >= msis_pkg::VOTE_MIN) begin
        vote[b] = 1'b0;
      end else begin
        vote[b] = filt_q[b];
      end
    end
  end

  assign filt_next_o = push_i ? vote : filt_q;

  // ring, pointer and filtered state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < msis_pkg::RING_DEPTH; k++) begin
        ring_q[k] <= '0;
      end
      ptr_q  <= '0;
      filt_q <= '0;
    end else if (push_i) begin
      ring_q[rp[PtrW-1:0]] <= data_i;
      ptr_q                <= ptr_d;
      filt_q               <= vote;
    end
  end

endmodule

### hw/rtl/muxed_input_sampler_with_selftest.sv
// Decoder input sampler with self-test.
// Slave channel s_*: one transfer per scheduler tick, carrying the byte read from
// the multiplexed decoder. Master channel m_*: one result transfer per input
// transfer, in order. Config channel cfg_*: writes the expected test pattern,
// always ready, to be written only while the block is idle.
// A round runs seven ticks: arm data select, issue it, read data, issue test
// select, three test reads. A 2-of-3 majority of the test reads that matches the
// pattern pushes the held data byte into a six-deep ring; each filtered bit moves
// when 4 of 6 samples agree. A mismatch raises test_fail instead.
// A result turns valid in the cycle after its input transfer; while the receiver
// does not stall, the block takes one item per cycle, since all work for a tick
// sits between the state registers and the output register.
// Reset clears the sequence to the arm phase, the ring and filtered state to zero,
// and the pattern to 0x7F. While the receiver stalls with a result held, s_tready_o
// drops and nothing is lost; a result taken frees the slot in the same cycle.
module muxed_input_sampler_with_selftest #(
  parameter int INPUT_WIDTH = msis_pkg::INPUT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // sample[7:0]
  input  logic [msis_pkg::SAMPLE_W-1:0] s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // mux_select[1:0], input_state[9:2], test_done[10], test_fail[11], zero[15:12]
  output logic [msis_pkg::RESULT_W-1:0] m_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [msis_pkg::SAMPLE_W-1:0] cfg_data_i
);

  localparam int DataW = (INPUT_WIDTH < msis_pkg::SAMPLE_W) ? INPUT_WIDTH :
                         msis_pkg::SAMPLE_W;

  logic                          accept;
  logic [DataW-1:0]              pattern_q;
  logic [DataW-1:0]              held_data;
  logic [DataW-1:0]              filt_next;
  logic [msis_pkg::SAMPLE_W-1:0] filt_ext;
  msis_pkg::seq_out_t            ctrl;
  logic                          m_tvalid_q;
  logic [msis_pkg::RESULT_W-1:0] m_tdata_q;

  // input transfer whenever the output slot is free or draining
  assign s_tready_o  = !m_tvalid_q || m_tready_i;
  assign accept      = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;

  // test pattern register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= DataW'(msis_pkg::PATTERN_RESET);
    end else if (cfg_valid_i) begin
      pattern_q <= cfg_data_i[DataW-1:0];
    end
  end

  msis_seq #(
    .DATA_W (DataW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .sample_i    (s_tdata_i[DataW-1:0]),
    .pattern_i   (pattern_q),
    .ctrl_o      (ctrl),
    .held_data_o (held_data)
  );

  msis_filter #(
    .DATA_W (DataW)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && ctrl.ring_push),
    .data_i      (held_data),
    .filt_next_o (filt_next)
  );

  assign filt_ext = msis_pkg::SAMPLE_W'(filt_next);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (accept) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_tdata_q <= {4'b0000, ctrl.test_fail, ctrl.test_done, ~filt_ext,
                    ctrl.mux_select};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

endmodule

### hw/rtl/msis_checker.sv
`include "assert_macros.svh"

module msis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tready_o,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [msis_pkg::RESULT_W-1:0] m_tdata_o
);

  // a stalled result holds
  `ASSERT_I(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "stall hold")

  // an empty output slot always takes input
  `ASSERT_I(a_ready_when_empty, !m_tvalid_o |-> s_tready_o, "input stalled with empty output")

  // a test failure only comes with a finished test
  `ASSERT_I(a_fail_needs_done, m_tvalid_o && m_tdata_o[11] |-> m_tdata_o[10], "fail without done")

  // no select command on the tick a test round finishes
  `ASSERT_I(a_done_no_sel, m_tvalid_o && m_tdata_o[10] |-> m_tdata_o[1:0] == 2'd0, "select on done")

  // padding bits of a result stay zero
  `ASSERT_I(a_pad_zero, m_tvalid_o |-> m_tdata_o[15:12] == 4'd0, "nonzero padding")

endmodule

bind muxed_input_sampler_with_selftest msis_checker u_msis_checker (.*);
